/* sv/trd_pkg.sv */
// Shared types and constants for the record deframer.
// Holds the verdict codes, the result word layout and header constants.
// No dependencies.
package trd_pkg;

    localparam logic [2:0]  HDR_LEN    = 3'd5;
    localparam logic [15:0] WRAP_LIMIT = 16'd65531;

    localparam logic       CFG_MAJOR = 1'b0;
    localparam logic       CFG_MINOR = 1'b1;
    localparam logic [7:0] MAJOR_RESET = 8'd3;
    localparam logic [7:0] MINOR_RESET = 8'd3;

    typedef enum logic [1:0] {
        V_OK        = 2'd0,
        V_SHORT_HDR = 2'd1,
        V_SHORT_PAY = 2'd2,
        V_BAD       = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        payload_valid;
        logic [7:0]  record_type;
        logic [15:0] record_length;
        logic        verdict_valid;
        verdict_t    verdict;
    } result_t;

endpackage

/* sv/tls_record_deframer.sv */
// Top level of the record deframer: parser front end, result queue and output stage.
// Depends on trd_pkg, trd_front, trd_queue and trd_back.
//
// The input channel takes one stream byte per word, with buffer_end marking the
// last byte of the buffer. Every accepted input word yields exactly one output
// word carrying the payload byte (if any), the current record type and length,
// and the record verdict when one is due.
// Throughput is one word per cycle while in_ready is high; the parser updates its header
// index and payload counter for each accepted byte. The result word enters the queue at
// the edge that accepts the input word and moves into the output register, where
// out_valid rises, once that register is free to take it.
// When the receiver stalls, results collect in the QUEUE_DEPTH-entry queue plus
// the output register; in_ready drops only when the queue is full.
// Reset clears the parser to expect a new header, empties the queue and sets
// both expected version bytes to 3. Config writes take effect on the next cycle.
module tls_record_deframer
    import trd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        payload_valid,
    output logic [7:0]  record_type,
    output logic [15:0] record_length,
    output logic        verdict_valid,
    output logic [1:0]  verdict
);

    logic    push_valid;
    logic    push_ready;
    result_t push_word;
    logic    pop_valid;
    logic    pop_ready;
    result_t pop_word;
    result_t out_word;

    assign in_ready = push_ready;

    trd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (push_ready),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .push_valid (push_valid),
        .push_word  (push_word)
    );

    trd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    trd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_word  (pop_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    assign out_byte      = out_word.out_byte;
    assign payload_valid = out_word.payload_valid;
    assign record_type   = out_word.record_type;
    assign record_length = out_word.record_length;
    assign verdict_valid = out_word.verdict_valid;
    assign verdict       = out_word.verdict;

endmodule

/* sv/trd_front.sv */
// Front end of the record deframer: header parser, payload counter and config registers.
// Produces one result word per accepted input word.
// Depends on trd_pkg.
module trd_front
    import trd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        buffer_end,
    output logic        push_valid,
    output result_t     push_word
);

    logic [7:0]  major_reg, major_next;
    logic [7:0]  minor_reg, minor_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [7:0]  type_reg, type_next;
    logic        vgood_reg, vgood_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] left_reg, left_next;
    logic        fire;
    logic        vvalid;
    verdict_t    vcode;
    verdict_t    rec_verdict;
    logic [15:0] left_dec;

    assign fire = in_valid && in_ready;
    assign push_valid = in_valid;
    assign left_dec = left_reg - 16'd1;
    assign rec_verdict = (vgood_reg && (type_reg != 8'd0)) ? V_OK : V_BAD;

    always_comb
    begin
        major_next = major_reg;
        minor_next = minor_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAJOR: major_next = cfg_data;
                CFG_MINOR: minor_next = cfg_data;
                default:   major_next = major_reg;
            endcase
        end
    end

    always_comb
    begin
        hdr_idx_next = hdr_idx_reg;
        type_next    = type_reg;
        vgood_next   = vgood_reg;
        len_next     = len_reg;
        left_next    = left_reg;
        vvalid       = 1'b0;
        vcode        = V_OK;
        push_word.out_byte      = 8'd0;
        push_word.payload_valid = 1'b0;
        if (hdr_idx_reg >= HDR_LEN)
        begin
            push_word.out_byte      = data_byte;
            push_word.payload_valid = 1'b1;
            left_next = left_dec;
            if (left_dec == 16'd0)
            begin
                vvalid = 1'b1;
                vcode  = rec_verdict;
            end
            else if (buffer_end)
            begin
                vvalid = 1'b1;
                vcode  = V_SHORT_PAY;
            end
        end
        else
        begin
            case (hdr_idx_reg)
                3'd0:
                begin
                    type_next  = data_byte;
                    len_next   = 16'd0;
                    vgood_next = 1'b1;
                end
                3'd1: vgood_next = vgood_reg && (data_byte == major_reg);
                3'd2: vgood_next = vgood_reg && (data_byte == minor_reg);
                3'd3: len_next = {data_byte, 8'd0};
                default: len_next = {len_reg[15:8], len_reg[7:0] | data_byte};
            endcase
            hdr_idx_next = hdr_idx_reg + 3'd1;
            if (hdr_idx_next == HDR_LEN)
            begin
                left_next = len_next;
                if (len_next >= WRAP_LIMIT)
                begin
                    vvalid = 1'b1;
                    vcode  = V_BAD;
                end
                else if (len_next == 16'd0)
                begin
                    vvalid = 1'b1;
                    vcode  = rec_verdict;
                end
                else if (buffer_end)
                begin
                    vvalid = 1'b1;
                    vcode  = V_SHORT_PAY;
                end
            end
            else if (buffer_end)
            begin
                vvalid = 1'b1;
                vcode  = V_SHORT_HDR;
            end
        end
        if (vvalid)
        begin
            hdr_idx_next = 3'd0;
            vgood_next   = 1'b1;
            left_next    = 16'd0;
        end
        push_word.record_type   = type_next;
        push_word.record_length = len_next;
        push_word.verdict_valid = vvalid;
        push_word.verdict       = vcode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg   <= MAJOR_RESET;
            minor_reg   <= MINOR_RESET;
            hdr_idx_reg <= 3'd0;
            type_reg    <= 8'd0;
            vgood_reg   <= 1'b1;
            len_reg     <= 16'd0;
            left_reg    <= 16'd0;
        end
        else
        begin
            major_reg <= major_next;
            minor_reg <= minor_next;
            if (fire)
            begin
                hdr_idx_reg <= hdr_idx_next;
                type_reg    <= type_next;
                vgood_reg   <= vgood_next;
                len_reg     <= len_next;
                left_reg    <= left_next;
            end
        end
    end

    a_verdict_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && push_word.verdict_valid |=> hdr_idx_reg == 3'd0 && left_reg == 16'd0)
        else $error("parser did not restart after a verdict");

    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        fire && push_word.payload_valid |-> hdr_idx_reg >= HDR_LEN)
        else $error("payload word emitted during header");

    a_idle_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !push_word.verdict_valid |-> push_word.verdict == V_OK)
        else $error("verdict code set without verdict_valid");

endmodule

/* sv/trd_queue.sv */
// Short result queue between the parser and the output stage.
// A circular buffer with a fill count; depth set by a parameter.
// Depends on trd_pkg.
module trd_queue
    import trd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  result_t push_word,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_word
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_word   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count exceeds depth");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire && !pop_fire |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

/* sv/trd_back.sv */
// Output stage of the record deframer: one registered result word toward the receiver.
// Takes a new word whenever it is empty or its word is being taken.
// Depends on trd_pkg.
module trd_back
    import trd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pop_valid,
    output logic    pop_ready,
    input  result_t pop_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    valid_reg, valid_next;
    result_t word_reg;

    assign pop_ready  = !valid_reg || out_ready;
    assign valid_next = pop_ready ? pop_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_word   = word_reg;

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
        begin
            word_reg <= pop_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

/* dv/tls_record_deframer_tb.sv */
// Self-checking testbench for tls_record_deframer: directed records, then random record streams.
// Expected words come from the directed table or a cycle-free parser predictor in this file.
// Depends on trd_pkg and the tls_record_deframer RTL.
module tls_record_deframer_tb;
    import trd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        buffer_end;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        payload_valid;
    logic [7:0]  record_type;
    logic [15:0] record_length;
    logic        verdict_valid;
    logic [1:0]  verdict;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        result_t    w;
    } dir_row_t;

    logic [7:0]  exp_major;
    logic [7:0]  exp_minor;
    logic [2:0]  hdr_idx;
    logic [7:0]  cur_type;
    logic        ver_ok;
    logic [15:0] cur_len;
    logic [15:0] remain;

    result_t pending_words [$];
    dir_row_t dir_rows [25];
    int n_bytes_sent;
    int n_words_checked;
    int n_errors;
    int n_verdicts [4];
    bit tx_busy;
    bit rx_busy;

    tls_record_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .buffer_end    (buffer_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .payload_valid (payload_valid),
        .record_type   (record_type),
        .record_length (record_length),
        .verdict_valid (verdict_valid),
        .verdict       (verdict)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic result_t make_word(input logic [7:0] ob, input logic pv,
                                          input logic [7:0] ty, input logic [15:0] ln,
                                          input logic vv, input verdict_t vd);
        result_t w;
        w.out_byte      = ob;
        w.payload_valid = pv;
        w.record_type   = ty;
        w.record_length = ln;
        w.verdict_valid = vv;
        w.verdict       = vd;
        return w;
    endfunction

    function automatic verdict_t record_outcome();
        return (ver_ok && cur_type != 8'h00) ? V_OK : V_BAD;
    endfunction

    function automatic void reset_parser();
        exp_major = MAJOR_RESET;
        exp_minor = MINOR_RESET;
        hdr_idx   = 3'd0;
        cur_type  = 8'h00;
        ver_ok    = 1'b1;
        cur_len   = 16'h0000;
        remain    = 16'h0000;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b, input logic fin);
        result_t w;
        w = '0;
        if (hdr_idx >= HDR_LEN)
        begin
            w.payload_valid = 1'b1;
            w.out_byte      = b;
            remain          = remain - 16'd1;
            if (remain == 16'd0)
            begin
                w.verdict_valid = 1'b1;
                w.verdict       = record_outcome();
            end
            else if (fin)
            begin
                w.verdict_valid = 1'b1;
                w.verdict       = V_SHORT_PAY;
            end
        end
        else
        begin
            case (hdr_idx)
                3'd0:
                begin
                    cur_type = b;
                    cur_len  = 16'h0000;
                    ver_ok   = 1'b1;
                end
                3'd1: if (b != exp_major) ver_ok = 1'b0;
                3'd2: if (b != exp_minor) ver_ok = 1'b0;
                3'd3: cur_len = {b, 8'h00};
                default: cur_len = cur_len | {8'h00, b};
            endcase
            hdr_idx = hdr_idx + 3'd1;
            if (hdr_idx == HDR_LEN)
            begin
                remain = cur_len;
                if (cur_len >= WRAP_LIMIT)
                begin
                    w.verdict_valid = 1'b1;
                    w.verdict       = V_BAD;
                end
                else if (cur_len == 16'd0)
                begin
                    w.verdict_valid = 1'b1;
                    w.verdict       = record_outcome();
                end
                else if (fin)
                begin
                    w.verdict_valid = 1'b1;
                    w.verdict       = V_SHORT_PAY;
                end
            end
            else if (fin)
            begin
                w.verdict_valid = 1'b1;
                w.verdict       = V_SHORT_HDR;
            end
        end
        if (w.verdict_valid)
        begin
            hdr_idx = 3'd0;
            ver_ok  = 1'b1;
            remain  = 16'h0000;
        end
        w.record_type   = cur_type;
        w.record_length = cur_len;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        n_errors++;
        if (n_errors <= 50)
            $display("MISMATCH word %0d %s: got %0h, wanted %0h", n_words_checked, what, got, want);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input result_t typed_word);
        int gap;
        result_t w;
        gap = (tx_busy && $urandom_range(0, 1) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        buffer_end <= fin;
        do @(posedge clk); while (!in_ready);
        w = parse_byte(b, fin);
        pending_words.push_back(typed ? typed_word : w);
        n_bytes_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] major, input logic [7:0] minor);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAJOR;
        cfg_data  <= major;
        @(posedge clk);
        cfg_index <= CFG_MINOR;
        cfg_data  <= minor;
        @(posedge clk);
        cfg_we    <= 1'b0;
        exp_major = major;
        exp_minor = minor;
        @(posedge clk);
    endtask

    task automatic send_record();
        logic [7:0] rec [$];
        logic [15:0] len;
        int pick;
        int n_pay;
        int cut;
        bit forced;
        bit fin;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = 16'd0;
        else if (pick < 85)
            len = 16'($urandom_range(1, 12));
        else if (pick < 92)
            len = 16'($urandom_range(13, 40));
        else
            len = 16'($urandom_range(65520, 65535));
        rec.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        rec.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : exp_major);
        rec.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : exp_minor);
        rec.push_back(len[15:8]);
        rec.push_back(len[7:0]);
        forced = 1'b0;
        if (len < WRAP_LIMIT)
        begin
            n_pay = (len < 16'd64) ? int'(len) : $urandom_range(0, 6);
            forced = (len >= 16'd64);
            repeat (n_pay) rec.push_back(8'($urandom_range(0, 255)));
        end
        cut = rec.size() - 1;
        if (!forced && $urandom_range(0, 4) == 0)
            cut = $urandom_range(0, rec.size() - 1);
        forced = forced || (cut < rec.size() - 1);
        fin = forced || ($urandom_range(0, 2) == 0);
        for (int k = 0; k <= cut; k++)
            send_byte(rec[k], (k == cut) && fin, 1'b0, '0);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++)
            send_byte(8'($urandom_range(0, 255)),
                      (k == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    initial
    begin
        result_t want;
        int stall;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = (rx_busy && $urandom_range(0, 1) == 0) ? $urandom_range(1, 13) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            n_words_checked++;
            if (verdict_valid === 1'b1)
                n_verdicts[verdict]++;
            if (pending_words.size() == 0)
            begin
                report_mismatch("arrived with nothing pending", 16'h0, 16'h0);
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_byte !== want.out_byte)
                    report_mismatch("out_byte", 16'(out_byte), 16'(want.out_byte));
                if (payload_valid !== want.payload_valid)
                    report_mismatch("payload_valid", 16'(payload_valid),
                                    16'(want.payload_valid));
                if (record_type !== want.record_type)
                    report_mismatch("record_type", 16'(record_type), 16'(want.record_type));
                if (record_length !== want.record_length)
                    report_mismatch("record_length", record_length, want.record_length);
                if (verdict_valid !== want.verdict_valid)
                    report_mismatch("verdict_valid", 16'(verdict_valid),
                                    16'(want.verdict_valid));
                if (verdict !== want.verdict)
                    report_mismatch("verdict", 16'(verdict), 16'(want.verdict));
            end
        end
    end

    initial
    begin
        int target;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_MAJOR;
        cfg_data   <= 8'h00;
        in_valid   <= 1'b0;
        data_byte  <= 8'h00;
        buffer_end <= 1'b0;
        tx_busy = 1'b0;
        rx_busy = 1'b0;
        n_bytes_sent = 0;
        n_words_checked = 0;
        n_errors = 0;
        n_verdicts = '{0, 0, 0, 0};
        reset_parser();

        // Complete record, zero-type record with a version fault, wrapping length,
        // header cut short, and a payload cut short that outranks a version fault.
        dir_rows = '{
            '{8'h16, 1'b0, 1'b1, make_word(8'h00, 1'b0, 8'h16, 16'h0000, 1'b0, V_OK)},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, make_word(8'hFF, 1'b1, 8'h16, 16'h0001, 1'b1, V_OK)},
            '{8'h00, 1'b0, 1'b1, make_word(8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, V_OK)},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1, make_word(8'h00, 1'b0, 8'h00, 16'h0000, 1'b1, V_BAD)},
            '{8'h17, 1'b0, 1'b0, '0},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, make_word(8'h00, 1'b0, 8'h17, 16'hFFFF, 1'b1, V_BAD)},
            '{8'h16, 1'b0, 1'b0, '0},
            '{8'h03, 1'b1, 1'b1, make_word(8'h00, 1'b0, 8'h16, 16'h0000, 1'b1, V_SHORT_HDR)},
            '{8'h16, 1'b0, 1'b0, '0},
            '{8'h04, 1'b0, 1'b0, '0},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b0, '0},
            '{8'h80, 1'b1, 1'b1, make_word(8'h80, 1'b1, 8'h16, 16'h0003, 1'b1, V_SHORT_PAY)}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].typed, dir_rows[i].w);

        for (int ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0: write_regs(8'h00, 8'h00);
                1: write_regs(8'hFF, 8'hFF);
                2: write_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: write_regs(MAJOR_RESET, MINOR_RESET);
            endcase
            tx_busy = (ph == 0 || ph == 2);
            rx_busy = (ph == 1 || ph == 2);
            target = n_bytes_sent + 195;
            while (n_bytes_sent < target)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_record();
            end
        end

        settle();
        repeat (8) @(posedge clk);
        $display("Sent %0d stream bytes across four version settings; checked %0d result words.",
                 n_bytes_sent, n_words_checked);
        $display("Verdicts: ok %0d, short header %0d, short payload %0d, bad record %0d.",
                 n_verdicts[0], n_verdicts[1], n_verdicts[2], n_verdicts[3]);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
sv/trd_pkg.sv
sv/trd_front.sv
sv/trd_queue.sv
sv/trd_back.sv
sv/tls_record_deframer.sv
dv/tls_record_deframer_tb.sv
